// File: rtl/streaming_pattern_replace_macros.svh
// Assertion macros for the streaming pattern replace block.
// Included by the top level; depends on nothing else.
`ifndef STREAMING_PATTERN_REPLACE_MACROS_SVH
`define STREAMING_PATTERN_REPLACE_MACROS_SVH

// Same-cycle implication, muted during reset.
`define SPR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, muted during reset.
`define SPR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/spr_pkg.sv
// Shared types and constants of the streaming pattern replace block.
// No dependencies; used by spr_cell and streaming_pattern_replace.
package spr_pkg;

   // window holds up to eight text bytes; one extra cell parks a newline
   localparam int          WIN_CELLS       = 9;
   localparam logic [3:0]  WIN_DEPTH       = 4'd8;
   localparam logic [3:0]  MAX_PATTERN     = 4'd8;
   localparam logic [3:0]  MAX_REPLACEMENT = 4'd8;
   localparam logic [7:0]  NEWLINE_CHAR    = 8'd10;

   // register indexes on the csr port
   localparam logic [2:0]  CSR_PATTERN_BYTES      = 3'd0;
   localparam logic [2:0]  CSR_PATTERN_LENGTH     = 3'd1;
   localparam logic [2:0]  CSR_REPLACEMENT_BYTES  = 3'd2;
   localparam logic [2:0]  CSR_REPLACEMENT_LENGTH = 3'd3;

   // per-cycle control broadcast along the cell row
   typedef struct packed {
      logic shift;   // every cell takes its right neighbor's byte
      logic write;   // the selected cell takes the incoming byte
   } cell_ctrl_type;

endpackage

// File: rtl/spr_cell.sv
// One window cell: holds a byte, shifts toward the head, compares to the pattern.
// Depends on spr_pkg.
module spr_cell (
   input  logic                   clock,
   input  spr_pkg::cell_ctrl_type ctrl,
   input  logic                   sel,         // this cell is the push slot
   input  logic [7:0]             right_byte,  // neighbor toward the tail
   input  logic [7:0]             in_byte,
   input  logic [7:0]             pat_byte,
   output logic [7:0]             byte_out,
   output logic                   match
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic [7:0] view;
   logic [7:0] cand;

   // contents after this cycle's pop, then with the tentative push
   assign view    = ctrl.shift ? right_byte : byte_ff;
   assign cand    = sel ? in_byte : view;
   assign match   = (cand == pat_byte);
   assign byte_in = (ctrl.write && sel) ? in_byte : view;
   assign byte_out = byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

// File: rtl/streaming_pattern_replace.sv
// Streaming find-and-replace: one text word in per cycle, one out per cycle, while
// rsp_ready holds and no word yields more than one result. An accepted word sets the
// pending pop or replacement count; the single output register then takes its results in order.
// A word yielding N > 1 results holds the input until its last one enters that register.
// Reset: synchronous, active high; window empty, registers at their reset values.
module streaming_pattern_replace (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_text_byte,
   input  logic        req_stream_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

`include "streaming_pattern_replace_macros.svh"

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [63:0] pat_bytes_ff;
   logic [3:0]  pat_len_ff;
   logic [63:0] rep_bytes_ff;
   logic [3:0]  rep_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_bytes_ff <= '0;
         pat_len_ff   <= 4'd1;
         rep_bytes_ff <= '0;
         rep_len_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            spr_pkg::CSR_PATTERN_BYTES:      pat_bytes_ff <= csr_wdata;
            spr_pkg::CSR_PATTERN_LENGTH:     pat_len_ff   <= csr_wdata[3:0];
            spr_pkg::CSR_REPLACEMENT_BYTES:  rep_bytes_ff <= csr_wdata;
            spr_pkg::CSR_REPLACEMENT_LENGTH: rep_len_ff   <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // saturated lengths
   logic [3:0] plen;
   logic [3:0] rlen;
   assign plen = (pat_len_ff > spr_pkg::MAX_PATTERN) ? spr_pkg::MAX_PATTERN : pat_len_ff;
   assign rlen = (rep_len_ff > spr_pkg::MAX_REPLACEMENT) ? spr_pkg::MAX_REPLACEMENT
                                                          : rep_len_ff;

   // ---------------------------------------------------------------
   // emit engine state
   // pop_left: words still to drain from the window head
   // rep_left: replacement words still to send
   // only one of the two is ever nonzero
   // ---------------------------------------------------------------
   logic [3:0]  fill_ff,     fill_in;
   logic [3:0]  pop_left_ff, pop_left_in;
   logic [3:0]  rep_left_ff, rep_left_in;
   logic [63:0] rep_sr_ff,   rep_sr_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff,  out_byte_in;
   logic        out_last_ff,  out_last_in;

   logic       out_free;
   logic       move;
   logic       pop_move;
   logic       rep_move;
   logic [3:0] pend;
   logic       fire;

   assign out_free = !out_valid_ff || rsp_ready;
   assign pend     = (pop_left_ff != 4'd0) ? pop_left_ff : rep_left_ff;
   assign move     = out_free && (pend != 4'd0);
   assign pop_move = move && (pop_left_ff != 4'd0);
   assign rep_move = move && (pop_left_ff == 4'd0);

   // a new word may enter once nothing is left to move after this cycle
   assign req_ready = (pend == 4'd0) || ((pend == 4'd1) && out_free);
   assign fire      = req_valid && req_ready;

   // ---------------------------------------------------------------
   // window: row of cells, head at index 0
   // ---------------------------------------------------------------
   logic [3:0]  fill_after;   // occupancy after this cycle's pop
   logic        is_newline;
   logic        do_push;
   logic [7:0]  cell_byte  [spr_pkg::WIN_CELLS];
   logic [spr_pkg::WIN_CELLS-1:0] cell_match;
   spr_pkg::cell_ctrl_type ctrl;

   assign fill_after = fill_ff - {3'd0, pop_move};
   assign is_newline = (req_text_byte == spr_pkg::NEWLINE_CHAR);
   // a full window drops further text; a newline parks in the spare cell
   assign do_push    = is_newline || (fill_after < spr_pkg::WIN_DEPTH);
   assign ctrl.shift = pop_move;
   assign ctrl.write = fire && do_push;

   for (genvar i = 0; i < spr_pkg::WIN_CELLS; i++) begin : g_cell
      logic [7:0] right;
      logic [7:0] pat;
      if (i == spr_pkg::WIN_CELLS - 1) begin : g_tail
         assign right = '0;
         assign pat   = '0;
      end else begin : g_body
         assign right = cell_byte[i+1];
         assign pat   = pat_bytes_ff[8*i +: 8];
      end
      spr_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .sel        (fill_after == 4'(i)),
         .right_byte (right),
         .in_byte    (req_text_byte),
         .pat_byte   (pat),
         .byte_out   (cell_byte[i]),
         .match      (cell_match[i])
      );
   end

   // pattern hit: every cell below the pattern length agrees
   logic hit_all;
   always_comb begin
      hit_all = 1'b1;
      for (int i = 0; i < spr_pkg::WIN_CELLS; i++) begin
         if (4'(i) < plen) begin
            hit_all = hit_all && cell_match[i];
         end
      end
   end

   // ---------------------------------------------------------------
   // per-word decision
   // ---------------------------------------------------------------
   logic [3:0] f1;         // occupancy with the new byte
   logic [3:0] excess;
   logic       full_len;   // window exactly pattern length
   logic       hit;
   logic [3:0] pops;

   assign f1       = fill_after + {3'd0, do_push};
   assign excess   = f1 - plen;
   assign full_len = (plen != 4'd0) && (f1 == plen);
   assign hit      = !is_newline && full_len && hit_all;

   always_comb begin
      priority if (is_newline) begin
         pops = f1;                       // flush, newline last
      end else if (f1 > plen) begin
         // shrunk pattern: release at most two oldest, or all at stream end
         pops = req_stream_end ? f1 : ((excess >= 4'd2) ? 4'd2 : 4'd1);
      end else if (full_len) begin
         pops = hit ? 4'd0 : (req_stream_end ? f1 : 4'd1);
      end else begin
         pops = req_stream_end ? f1 : 4'd0;
      end
   end

   // ---------------------------------------------------------------
   // next state
   // ---------------------------------------------------------------
   always_comb begin
      fill_in     = fill_after;
      pop_left_in = pop_left_ff - {3'd0, pop_move};
      rep_left_in = rep_left_ff - {3'd0, rep_move};
      rep_sr_in   = rep_move ? (rep_sr_ff >> 8) : rep_sr_ff;
      if (fire) begin
         fill_in     = hit ? 4'd0 : f1;
         pop_left_in = pops;
         rep_left_in = hit ? rlen : 4'd0;
         if (hit) begin
            rep_sr_in = rep_bytes_ff;
         end
      end
   end

   // output register: head byte or next replacement byte
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (move) begin
         out_valid_in = 1'b1;
         out_byte_in  = pop_move ? cell_byte[0] : rep_sr_ff[7:0];
         out_last_in  = (pend == 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         pop_left_ff  <= '0;
         rep_left_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         pop_left_ff  <= pop_left_in;
         rep_left_ff  <= rep_left_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rep_sr_ff   <= rep_sr_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_run_last = out_last_ff;

   // ---------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------
   `SPR_ASSERT_NOW(a_pops_backed, clock, reset, 1'b1, pop_left_ff <= fill_ff, "pops exceed window fill")
   `SPR_ASSERT_NOW(a_one_source, clock, reset, pop_left_ff != 4'd0, rep_left_ff == 4'd0, "pop and replacement both pending")
   `SPR_ASSERT_NXT(a_fill_bound, clock, reset, fire, fill_ff <= 4'(spr_pkg::WIN_CELLS), "window overflow")

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for streaming_pattern_replace: random idling on both
// handshakes, a scoreboard class with its own find-and-replace predictor.
// Depends on spr_pkg and the streaming_pattern_replace RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // ---------------------------------------------------------------------------
   // Scoreboard: keeps its own copy of the window and the registers, predicts
   // the rewritten words for every accepted text word, checks them in order.
   // ---------------------------------------------------------------------------
   class replace_scoreboard_type;
      typedef struct packed {
         logic [7:0] ch;
         logic       last;
      } rewritten_type;

      logic [63:0]   pat_bytes;
      logic [3:0]    pat_len;
      logic [63:0]   rep_bytes;
      logic [3:0]    rep_len;
      logic [7:0]    window [8];
      int unsigned   fill;
      rewritten_type rewritten_q [$];
      rewritten_type step_q [$];
      int unsigned   errors;

      function new();
         pat_bytes = '0;
         pat_len   = 4'd1;
         rep_bytes = '0;
         rep_len   = 4'd0;
         fill      = 0;
         errors    = 0;
         foreach (window[i]) window[i] = 8'h00;
      endfunction

      function void set_reg(logic [2:0] idx, logic [63:0] data);
         case (idx)
            spr_pkg::CSR_PATTERN_BYTES:      pat_bytes = data;
            spr_pkg::CSR_PATTERN_LENGTH:     pat_len   = data[3:0];
            spr_pkg::CSR_REPLACEMENT_BYTES:  rep_bytes = data;
            spr_pkg::CSR_REPLACEMENT_LENGTH: rep_len   = data[3:0];
            default: ;
         endcase
      endfunction

      function void emit_char(logic [7:0] ch);
         rewritten_type w;
         w.ch   = ch;
         w.last = 1'b0;
         step_q.push_back(w);
      endfunction

      function void release_oldest();
         if (fill == 0) return;
         emit_char(window[0]);
         for (int i = 1; i < fill && i < 8; i++) window[i-1] = window[i];
         fill--;
      endfunction

      function void flush_all();
         while (fill > 0) release_oldest();
      endfunction

      function bit window_is_pattern(int unsigned len);
         for (int i = 0; i < len && i < 8; i++)
            if (window[i] != pat_bytes[8*i +: 8]) return 1'b0;
         return 1'b1;
      endfunction

      // one accepted text word -> zero or more rewritten words
      function void apply_text_byte(logic [7:0] ch, logic at_end);
         int unsigned plen;
         int unsigned rlen;
         plen = (pat_len > spr_pkg::MAX_PATTERN) ? spr_pkg::MAX_PATTERN : pat_len;
         rlen = (rep_len > spr_pkg::MAX_REPLACEMENT) ? spr_pkg::MAX_REPLACEMENT : rep_len;
         step_q.delete();
         if (ch == spr_pkg::NEWLINE_CHAR) begin
            flush_all();
            emit_char(ch);
         end else begin
            if (fill < 8) begin
               window[fill] = ch;
               fill++;
            end
            if (fill > plen) begin
               // shrunk pattern: release up to two, no compare this word
               release_oldest();
               if (fill > plen) release_oldest();
            end else if (plen > 0 && fill == plen) begin
               if (window_is_pattern(plen)) begin
                  for (int i = 0; i < rlen; i++) emit_char(rep_bytes[8*i +: 8]);
                  fill = 0;
               end else begin
                  release_oldest();
               end
            end
            if (at_end) flush_all();
         end
         if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
         foreach (step_q[i]) rewritten_q.push_back(step_q[i]);
      endfunction

      task report(string msg);
         errors++;
         $display("mismatch at %0t: %s", $realtime, msg);
      endtask

      task check_rewritten(logic [7:0] ch, logic last);
         rewritten_type want;
         if (rewritten_q.size() == 0) begin
            report($sformatf("unexpected word %02h last %0b", ch, last));
         end else begin
            want = rewritten_q.pop_front();
            if (ch !== want.ch)
               report($sformatf("out_byte %02h, predicted %02h", ch, want.ch));
            if (last !== want.last)
               report($sformatf("run_last %0b, predicted %0b", last, want.last));
         end
      endtask
   endclass

   // ---------------------------------------------------------------------------
   // DUT and stimulus signals; every stimulus signal known from time zero
   // ---------------------------------------------------------------------------
   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic [7:0]  req_text_byte  = 8'h00;
   logic        req_stream_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_last;
   logic        csr_we         = 1'b0;
   logic [2:0]  csr_index      = spr_pkg::CSR_PATTERN_BYTES;
   logic [63:0] csr_wdata      = '0;

   // calm flags switch off idling on one side for a whole phase
   bit send_calm = 1'b0;
   bit recv_calm = 1'b0;

   replace_scoreboard_type sb = new();

   streaming_pattern_replace dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_text_byte  (req_text_byte),
      .req_stream_end (req_stream_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   // monitor: both handshakes sampled at the edge, values from before the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.apply_text_byte(req_text_byte, req_stream_end);
         if (rsp_valid && rsp_ready) sb.check_rewritten(rsp_out_byte, rsp_run_last);
      end
   end

   // receiver: random stall drawn per result word
   initial begin
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         stall = recv_calm ? 0 : $urandom_range(0, 13);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // ---------------------------------------------------------------------------
   // Driver tasks
   // ---------------------------------------------------------------------------
   // valid stays up across back-to-back words; only lowered for a gap
   task automatic send_word(logic [7:0] ch, logic at_end);
      int unsigned gap;
      gap = send_calm ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_text_byte  <= ch;
      req_stream_end <= at_end;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop sending and wait for every predicted word, then let the pipe settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.rewritten_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [63:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.set_reg(idx, data);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_replace(logic [63:0] pat, logic [63:0] plen,
                                  logic [63:0] rep, logic [63:0] rlen);
      write_csr(spr_pkg::CSR_PATTERN_BYTES, pat);
      write_csr(spr_pkg::CSR_PATTERN_LENGTH, plen);
      write_csr(spr_pkg::CSR_REPLACEMENT_BYTES, rep);
      write_csr(spr_pkg::CSR_REPLACEMENT_LENGTH, rlen);
   endtask

   // well-formed runs: whole patterns, prefixes, pattern chars, newlines, noise
   task automatic send_random_run(int unsigned count);
      int unsigned sent;
      int unsigned kind;
      int unsigned plen;
      int unsigned n;
      logic [7:0]  ch;
      sent = 0;
      plen = (sb.pat_len > spr_pkg::MAX_PATTERN) ? spr_pkg::MAX_PATTERN : sb.pat_len;
      while (sent < count) begin
         kind = $urandom_range(0, 9);
         if (plen == 0 && kind < 6) kind = 9;
         if (kind < 6) begin
            // full pattern or a broken prefix of it
            n = (kind < 4) ? plen : $urandom_range(1, plen);
            for (int i = 0; i < n; i++) begin
               send_word(sb.pat_bytes[8*i +: 8], $urandom_range(0, 19) == 0);
               sent++;
            end
         end else begin
            if (kind == 6)
               ch = spr_pkg::NEWLINE_CHAR;
            else if (kind < 9 && plen > 0)
               ch = sb.pat_bytes[8*$urandom_range(0, plen-1) +: 8];
            else
               ch = 8'($urandom_range(0, 255));
            send_word(ch, $urandom_range(0, 19) == 0);
            sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   int unsigned plen_tab [8] = '{8, 1, 3, 5, 2, 12, 0, 4};
   int unsigned rlen_tab [8] = '{0, 8, 3, 15, 1, 8, 2, 6};

   initial begin
      logic [63:0] pat;
      logic [63:0] upper;
      int unsigned k;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset registers: pattern is one 0x00 byte, deleted -> no word for it
      send_word(8'h00, 1'b0);
      send_word(spr_pkg::NEWLINE_CHAR, 1'b0);
      send_word(8'hFF, 1'b1);
      drain();

      // "ab" -> "XYZ"; newline flushes a pending partial match
      program_replace(64'h6261, 64'd2, 64'h5A5958, 64'd3);
      send_word(8'h78, 1'b0);
      send_word(8'h61, 1'b0);
      send_word(8'h61, 1'b0);
      send_word(8'h62, 1'b0);
      send_word(8'h61, 1'b0);
      send_word(spr_pkg::NEWLINE_CHAR, 1'b0);
      send_word(8'h61, 1'b1);
      drain();

      // lengths above the maximum saturate: eight 0xFF -> eight replacement words
      program_replace({64{1'b1}}, 64'd15, 64'h0123456789ABCDEF, 64'd15);
      for (int i = 0; i < 8; i++) send_word(8'hFF, i == 7);
      drain();

      // empty pattern: plain pass-through
      write_csr(spr_pkg::CSR_PATTERN_LENGTH, 64'd0);
      send_word(8'h41, 1'b0);
      send_word(8'h42, 1'b1);
      drain();

      // newline as pattern never matches
      program_replace({56'h0, spr_pkg::NEWLINE_CHAR}, 64'd1, 64'h21, 64'd1);
      send_word(spr_pkg::NEWLINE_CHAR, 1'b0);
      send_word(8'h0B, 1'b1);
      drain();

      // shrunk pattern: five bytes pending under length 8, then length 2
      program_replace(64'h5050505050505050, 64'd8, 64'h2A, 64'd1);
      for (int i = 0; i < 5; i++) send_word(8'(8'h61 + i), 1'b0);
      drain();
      write_csr(spr_pkg::CSR_PATTERN_LENGTH, 64'd2);
      send_word(8'h66, 1'b0);
      send_word(8'h67, 1'b0);
      send_word(8'h68, 1'b1);
      drain();

      // random phases; extremes of both lengths in the table, junk above bit 3
      for (int ph = 0; ph < 8; ph++) begin
         pat = {$urandom, $urandom};
         if (ph == 2) pat = '0;
         if (ph == 4) pat = {64{1'b1}};
         if ($urandom_range(0, 3) == 0) begin
            k = $urandom_range(0, 7);
            pat[8*k +: 8] = spr_pkg::NEWLINE_CHAR;
         end
         upper = {$urandom, $urandom};
         program_replace(pat, {upper[63:4], plen_tab[ph][3:0]},
                         {$urandom, $urandom}, {upper[59:0], rlen_tab[ph][3:0]});
         send_calm = (ph % 3 == 1);
         recv_calm = (ph % 3 == 2);
         send_random_run(18);
         // mid-phase hold-off until every predicted word has come back
         if (ph == 3) drain();
         send_random_run(17);
         drain();
      end

      // drain() has already waited out the last words; settle a little more
      repeat (10) @(posedge clock);
      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/spr_pkg.sv
rtl/spr_cell.sv
rtl/streaming_pattern_replace.sv
tb/sv/tb.sv
